### hw/rtl/pixel_to_rgb_colormap_core_macros.svh
// Assertion helpers used by the colormap core.
`ifndef PIXEL_TO_RGB_COLORMAP_CORE_MACROS_SVH
`define PIXEL_TO_RGB_COLORMAP_CORE_MACROS_SVH

// Same-cycle implication, sampled on aclk and quiet while reset is held.
`define CMAP_ASSERT_SAME(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("colormap assertion failed");

// Next-cycle implication, sampled on aclk and quiet while reset is held.
`define CMAP_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("colormap assertion failed");

`endif

### hw/rtl/cmap_pkg.sv
package cmap_pkg;

    // Storage for breakpoint registers; the number in use is clamped separately.
    localparam int POINT_REGS = 5;
    localparam int PIDX_W     = 3;
    localparam int SPAN_W     = 34;
    localparam int NUM_W      = 43;
    localparam int REM_W      = 45;

    // Configuration register indexes.
    typedef enum logic [2:0] {
        REG_POINT_COUNT = 3'd0,
        REG_POINT_0     = 3'd1,
        REG_POINT_1     = 3'd2,
        REG_POINT_2     = 3'd3,
        REG_POINT_3     = 3'd4,
        REG_POINT_4     = 3'd5,
        REG_CHAN_MIN    = 3'd6,
        REG_CHAN_MAX    = 3'd7
    } reg_idx_t;

    // Pixel modes.
    typedef enum logic [1:0] {
        MODE_GRAY   = 2'd0,
        MODE_SCALAR = 2'd1,
        MODE_BGR    = 2'd2,
        MODE_NORM   = 2'd3
    } mode_t;

    typedef logic signed [31:0] pval_t;
    typedef pval_t pval_arr_t [POINT_REGS];

    // Operands of one lane: result = round((c0*(span-off) + c1*off) / span).
    typedef struct packed {
        logic [7:0]        c0;
        logic [7:0]        c1;
        logic [SPAN_W-1:0] span;
        logic [SPAN_W-1:0] off;
    } lane_op_t;

    // Sequencer controls for the lanes.
    typedef struct packed {
        logic       mul_en;
        logic       div_init;
        logic       div_step;
        logic [2:0] bit_idx;
    } lane_ctl_t;

    // Bracket found by the breakpoint search.
    typedef struct packed {
        logic              flat;
        logic [PIDX_W-1:0] lo;
        logic [PIDX_W-1:0] hi;
    } srch_t;

endpackage

### hw/rtl/pixel_to_rgb_colormap_core.sv
// Channel   Dir  Handshake            Payload
// s_        in   s_tvalid / s_tready  s_tuser: mode; s_tdata: scalar, blue, green, red
// m_        out  m_tvalid / m_tready  m_tdata: red, green, blue
// cfg_      in   cfg_we               cfg_index, cfg_wdata
//
// A pixel accepted at one edge passes operand setup, multiply, divider setup, eight quotient
// steps and the write-out to the output register; a new pixel is taken only after the
// write-out, which waits while an untaken result is held. Each lane divides bit-serially.
// The next pixel is accepted while the previous result still waits on m_tready.
// Reset is synchronous and active low; it restores the register defaults.
`include "pixel_to_rgb_colormap_core_macros.svh"

module pixel_to_rgb_colormap_core #(
    parameter int NUM_POINTS = 5
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [1:0]  s_tuser,   // [1:0] mode
    input  logic [79:0] s_tdata,   // [31:0] scalar_value, [47:32] chan_b, [63:48] chan_g,
                                   // [79:64] chan_r
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,   // [7:0] red, [15:8] green, [23:16] blue
    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [55:0] cfg_wdata
);
    import cmap_pkg::*;

    typedef enum logic [5:0] {
        ST_IDLE = 6'b000001,
        ST_PREP = 6'b000010,
        ST_MUL  = 6'b000100,
        ST_INIT = 6'b001000,
        ST_DIV  = 6'b010000,
        ST_DONE = 6'b100000
    } state_t;

    state_t            state_reg, state_next;
    logic [2:0]        bit_reg, bit_next;
    logic [2:0]        count_reg;
    logic [55:0]       point_reg [POINT_REGS];
    logic [47:0]       min_reg;
    logic [47:0]       max_reg;
    mode_t             mode_reg;
    logic [79:0]       data_reg;
    lane_op_t          op_reg [3];
    lane_op_t          op_next [3];
    lane_ctl_t         ctl;
    logic [7:0]        lane_res [3];
    logic              m_valid_reg;
    logic [23:0]       m_data_reg;
    pval_arr_t         pvals;
    srch_t             srch;
    logic              out_load;

    // Configuration writes.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= 3'd2;
            for (int k = 0; k < POINT_REGS; k++) begin
                point_reg[k] <= '0;
            end
            point_reg[1] <= 56'h0001_0000_FFFFFF;
            min_reg      <= 48'h8100_8100_8100;
            max_reg      <= 48'h7F00_7F00_7F00;
        end else if (cfg_we) begin
            unique case (cfg_index)
                REG_POINT_COUNT: count_reg <= cfg_wdata[2:0];
                REG_POINT_0, REG_POINT_1, REG_POINT_2, REG_POINT_3, REG_POINT_4: begin
                    point_reg[cfg_index - 3'd1] <= cfg_wdata;
                end
                REG_CHAN_MIN: min_reg <= cfg_wdata[47:0];
                REG_CHAN_MAX: max_reg <= cfg_wdata[47:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        for (int k = 0; k < POINT_REGS; k++) begin
            pvals[k] = $signed(point_reg[k][55:24]);
        end
    end

    cmap_search #(
        .NUM_POINTS(NUM_POINTS)
    ) u_search (
        .value       ($signed(data_reg[31:0])),
        .point_count (count_reg),
        .pvals       (pvals),
        .result      (srch)
    );

    // Lane operands; lane 0 is red, 1 green, 2 blue.
    always_comb begin
        logic signed [32:0] span_s;
        logic signed [32:0] off_s;
        logic signed [16:0] x_s;
        logic signed [16:0] mn_s;
        logic signed [16:0] mx_s;
        logic [1:0]         ch;
        span_s = $signed({pvals[srch.hi][31], pvals[srch.hi]})
               - $signed({pvals[srch.lo][31], pvals[srch.lo]});
        off_s  = $signed({data_reg[31], data_reg[31:0]})
               - $signed({pvals[srch.lo][31], pvals[srch.lo]});
        for (int l = 0; l < 3; l++) begin
            // Min/max and input fields use blue = 0, green = 1, red = 2.
            ch   = 2'(2 - l);
            x_s  = $signed({data_reg[32 + 16*ch + 15], data_reg[32 + 16*ch +: 16]});
            mn_s = $signed({min_reg[16*ch + 15], min_reg[16*ch +: 16]});
            mx_s = $signed({max_reg[16*ch + 15], max_reg[16*ch +: 16]});
            op_next[l].c0   = '0;
            op_next[l].c1   = '0;
            op_next[l].span = SPAN_W'(1);
            op_next[l].off  = '0;
            case (mode_reg)
                MODE_GRAY: begin
                    op_next[l].c1  = data_reg[7:0];
                    op_next[l].off = SPAN_W'(1);
                end
                MODE_BGR: begin
                    op_next[l].c1  = data_reg[32 + 16*ch +: 8];
                    op_next[l].off = SPAN_W'(1);
                end
                MODE_NORM: begin
                    if (mx_s > mn_s) begin
                        op_next[l].c1   = 8'd255;
                        op_next[l].span = SPAN_W'(unsigned'(mx_s - mn_s));
                        if (x_s > mn_s) begin
                            op_next[l].off = SPAN_W'(unsigned'(x_s - mn_s));
                        end
                    end
                end
                default: begin
                    if (srch.flat) begin
                        op_next[l].c1  = point_reg[srch.lo][8*l +: 8];
                        op_next[l].off = SPAN_W'(1);
                    end else begin
                        op_next[l].c0   = point_reg[srch.lo][8*l +: 8];
                        op_next[l].c1   = point_reg[srch.hi][8*l +: 8];
                        op_next[l].span = SPAN_W'(unsigned'(span_s));
                        op_next[l].off  = SPAN_W'(unsigned'(off_s));
                    end
                end
            endcase
        end
    end

    // Sequencer.
    assign s_tready = (state_reg == ST_IDLE);
    assign out_load = (state_reg == ST_DONE) && (!m_valid_reg || m_tready);

    always_comb begin
        state_next = state_reg;
        bit_next   = bit_reg;
        unique case (state_reg)
            ST_IDLE: if (s_tvalid) state_next = ST_PREP;
            ST_PREP: state_next = ST_MUL;
            ST_MUL:  state_next = ST_INIT;
            ST_INIT: begin
                state_next = ST_DIV;
                bit_next   = 3'd7;
            end
            ST_DIV: begin
                bit_next = bit_reg - 3'd1;
                if (bit_reg == 3'd0) state_next = ST_DONE;
            end
            ST_DONE: if (out_load) state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        ctl.mul_en   = (state_reg == ST_MUL);
        ctl.div_init = (state_reg == ST_INIT);
        ctl.div_step = (state_reg == ST_DIV);
        ctl.bit_idx  = bit_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            bit_reg   <= '0;
        end else begin
            state_reg <= state_next;
            bit_reg   <= bit_next;
        end
    end

    // Input capture and operand registers.
    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            mode_reg <= mode_t'(s_tuser);
            data_reg <= s_tdata;
        end
        if (state_reg == ST_PREP) begin
            for (int l = 0; l < 3; l++) begin
                op_reg[l] <= op_next[l];
            end
        end
    end

    // One divider lane per output channel.
    for (genvar l = 0; l < 3; l++) begin : g_lane
        cmap_lane u_lane (
            .aclk   (aclk),
            .op     (op_reg[l]),
            .ctl    (ctl),
            .result (lane_res[l])
        );
    end

    // Merge the lanes into the output register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (out_load) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
        if (out_load) begin
            m_data_reg <= {lane_res[2], lane_res[1], lane_res[0]};
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

    `CMAP_ASSERT_NEXT(a_accept_starts, s_tvalid && s_tready, state_reg == ST_PREP)
    `CMAP_ASSERT_NEXT(a_div_ends, state_reg == ST_DIV && bit_reg == 3'd0, state_reg == ST_DONE)
    `CMAP_ASSERT_NEXT(a_load_shows, out_load, m_tvalid)
    `CMAP_ASSERT_SAME(a_idle_only_ready, s_tready, !ctl.div_step && !ctl.mul_en)

endmodule

### hw/rtl/cmap_search.sv
module cmap_search #(
    parameter int NUM_POINTS = 5
) (
    input  logic signed [31:0]  value,
    input  logic [2:0]          point_count,
    input  cmap_pkg::pval_arr_t pvals,
    output cmap_pkg::srch_t     result
);
    import cmap_pkg::*;

    logic [PIDX_W-1:0] n_used;
    logic [PIDX_W-1:0] first_idx;
    logic              found;

    // Clamp the breakpoint count into one..NUM_POINTS.
    always_comb begin
        if (point_count == 3'd0) begin
            n_used = PIDX_W'(1);
        end else if (point_count > PIDX_W'(NUM_POINTS)) begin
            n_used = PIDX_W'(NUM_POINTS);
        end else begin
            n_used = point_count;
        end
    end

    // Priority search for the first breakpoint in use at or above the value.
    always_comb begin
        found     = 1'b0;
        first_idx = n_used;
        for (int k = 0; k < POINT_REGS; k++) begin
            if (!found && (PIDX_W'(k) < n_used) && (value <= pvals[k])) begin
                found     = 1'b1;
                first_idx = PIDX_W'(k);
            end
        end
    end

    // Below the first or past the last breakpoint the end color is used as is.
    always_comb begin
        if (first_idx == '0) begin
            result.flat = 1'b1;
            result.lo   = '0;
            result.hi   = '0;
        end else if (first_idx == n_used) begin
            result.flat = 1'b1;
            result.lo   = n_used - PIDX_W'(1);
            result.hi   = n_used - PIDX_W'(1);
        end else begin
            result.flat = 1'b0;
            result.lo   = first_idx - PIDX_W'(1);
            result.hi   = first_idx;
        end
    end

endmodule

### hw/rtl/cmap_lane.sv
module cmap_lane (
    input  logic                aclk,
    input  cmap_pkg::lane_op_t  op,
    input  cmap_pkg::lane_ctl_t ctl,
    output logic [7:0]          result
);
    import cmap_pkg::*;

    logic [NUM_W-1:0]  num_reg;
    logic [SPAN_W-1:0] span_reg;
    logic [REM_W-1:0]  rem_reg;
    logic [REM_W-1:0]  rem_next;
    logic [REM_W-1:0]  div_reg;
    logic [7:0]        q_reg;
    logic [7:0]        q_next;
    logic              sat_reg;
    logic [NUM_W-1:0]  num_next;
    logic [REM_W-1:0]  init_rem;
    logic [REM_W-1:0]  init_div;
    logic [REM_W-1:0]  trial;

    // Weighted sum of the two end colors.
    always_comb begin
        num_next = NUM_W'(op.c0) * NUM_W'(op.span - op.off)
                 + NUM_W'(op.c1) * NUM_W'(op.off);
    end

    // Rounded quotient: floor((2N + D) / 2D); a quotient of 256 or more saturates.
    always_comb begin
        init_rem = (REM_W'(num_reg) << 1) + REM_W'(span_reg);
        init_div = REM_W'(span_reg) << 1;
        trial    = div_reg << ctl.bit_idx;
        rem_next = rem_reg;
        q_next   = q_reg;
        if (rem_reg >= trial) begin
            rem_next = rem_reg - trial;
            q_next   = q_reg | (8'd1 << ctl.bit_idx);
        end
    end

    // Multiply stage, then one quotient bit per cycle.
    always_ff @(posedge aclk) begin
        if (ctl.mul_en) begin
            num_reg  <= num_next;
            span_reg <= op.span;
        end
        if (ctl.div_init) begin
            rem_reg <= init_rem;
            div_reg <= init_div;
            sat_reg <= (init_rem >= (init_div << 8));
            q_reg   <= '0;
        end else if (ctl.div_step) begin
            rem_reg <= rem_next;
            q_reg   <= q_next;
        end
    end

    assign result = sat_reg ? 8'hFF : q_reg;

endmodule

### verif/tb.sv
`timescale 1ns / 1ps

module tb;
    import cmap_pkg::*;

    // Configuration register bounds and fixed-point reset values.
    localparam int MAX_POINTS    = 5;
    localparam int LATENCY_WAIT  = 40;
    localparam int RANDOM_ITEMS  = 1900;
    localparam logic [55:0] PT1_RESET  = 56'd1099528404991;
    localparam logic [47:0] CMIN_RESET = 48'd141839164276992;
    localparam logic [47:0] CMAX_RESET = 48'd139640107466496;

    typedef struct packed {
        logic [7:0] blue;
        logic [7:0] green;
        logic [7:0] red;
    } rgb_t;

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [1:0]  s_tuser;
    logic [79:0] s_tdata;
    logic        m_tvalid;
    logic        m_tready;
    logic [23:0] m_tdata;
    logic        cfg_we;
    logic [2:0]  cfg_index;
    logic [55:0] cfg_wdata;

    // Shadow copy of the configuration registers.
    logic [2:0]  shadow_count;
    logic [55:0] shadow_points [MAX_POINTS];
    logic [47:0] shadow_min;
    logic [47:0] shadow_max;

    rgb_t pending_pixels [$];
    int   error_count;
    bit   hold_off;

    pixel_to_rgb_colormap_core #(.NUM_POINTS(MAX_POINTS)) u_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tuser   (s_tuser),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    always begin
        aclk = 1'b1;
        #5;
        aclk = 1'b0;
        #5;
    end

    // Signed 32-bit breakpoint value of a point register.
    function automatic longint point_val(logic [55:0] p);
        return longint'($signed(p[55:24]));
    endfunction

    // Interpolates one colour byte between two breakpoints, ties rounding up.
    function automatic logic [7:0] blend_byte(longint v0, longint v1, longint v,
                                              logic [7:0] c0, logic [7:0] c1);
        longint span;
        longint off;
        longint total;
        span  = v1 - v0;
        off   = v - v0;
        total = longint'(c0) * (span - off) + longint'(c1) * off;
        return 8'((2 * total + span) / (2 * span));
    endfunction

    // Scales one Q8.8 channel into 0..255 against its min/max range.
    function automatic logic [7:0] scale_channel(logic [15:0] x, logic [15:0] lo,
                                                 logic [15:0] hi);
        longint xv;
        longint mn;
        longint mx;
        longint num;
        longint den;
        longint q;
        xv = longint'($signed(x));
        mn = longint'($signed(lo));
        mx = longint'($signed(hi));
        if (mx <= mn) return 8'd0;
        num = (xv - mn) * 255;
        if (num <= 0) return 8'd0;
        den = mx - mn;
        q = (2 * num + den) / (2 * den);
        return (q > 255) ? 8'd255 : 8'(q);
    endfunction

    // Computes the expected RGB pixel for one input transaction.
    function automatic rgb_t convert_pixel(mode_t mode, logic [79:0] data);
        rgb_t   px;
        longint v;
        int     n;
        int     i;
        int     k;
        v = longint'($signed(data[31:0]));
        case (mode)
            MODE_GRAY: begin
                px.red = data[7:0];
                px.green = data[7:0];
                px.blue = data[7:0];
            end
            MODE_BGR: begin
                px.blue  = data[39:32];
                px.green = data[55:48];
                px.red   = data[71:64];
            end
            MODE_NORM: begin
                px.blue  = scale_channel(data[47:32], shadow_min[15:0], shadow_max[15:0]);
                px.green = scale_channel(data[63:48], shadow_min[31:16], shadow_max[31:16]);
                px.red   = scale_channel(data[79:64], shadow_min[47:32], shadow_max[47:32]);
            end
            default: begin
                n = int'(shadow_count);
                if (n < 1) n = 1;
                if (n > MAX_POINTS) n = MAX_POINTS;
                i = 0;
                while (i < n && v > point_val(shadow_points[i])) i++;
                if (i == 0 || i == n) begin
                    k = (i == 0) ? 0 : n - 1;
                    px.red   = shadow_points[k][7:0];
                    px.green = shadow_points[k][15:8];
                    px.blue  = shadow_points[k][23:16];
                end else begin
                    px.red   = blend_byte(point_val(shadow_points[i-1]),
                                          point_val(shadow_points[i]), v,
                                          shadow_points[i-1][7:0], shadow_points[i][7:0]);
                    px.green = blend_byte(point_val(shadow_points[i-1]),
                                          point_val(shadow_points[i]), v,
                                          shadow_points[i-1][15:8], shadow_points[i][15:8]);
                    px.blue  = blend_byte(point_val(shadow_points[i-1]),
                                          point_val(shadow_points[i]), v,
                                          shadow_points[i-1][23:16], shadow_points[i][23:16]);
                end
            end
        endcase
        return px;
    endfunction

    task automatic report_mismatch(string what, logic [7:0] got, logic [7:0] want);
        $display("tb: %s mismatch at %0t: got %0d, expected %0d", what, $realtime, got, want);
        error_count++;
    endtask

    // Random gap length: mostly short, occasionally long.
    function automatic int gap_len();
        if ($urandom_range(0, 19) == 0) return $urandom_range(10, 40);
        if ($urandom_range(0, 1) == 0) return 0;
        return $urandom_range(1, 3);
    endfunction

    // Sends one pixel transaction and records its expected result.
    // Valid stays high after acceptance until the next call or a drain lowers it.
    task automatic send_pixel(mode_t mode, logic [79:0] data, bit gaps);
        int idle;
        idle = gaps ? gap_len() : 0;
        if (idle > 0) begin
            s_tvalid <= 1'b0;
            repeat (idle) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= mode;
        s_tdata  <= data;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        pending_pixels = {pending_pixels, convert_pixel(mode, data)};
    endtask

    function automatic logic [79:0] pack_pixel(logic [31:0] sv, logic [15:0] b,
                                               logic [15:0] g, logic [15:0] r);
        return {r, g, b, sv};
    endfunction

    // Writes one register while the block is idle.
    task automatic write_reg(reg_idx_t idx, logic [55:0] value);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= value;
        @(posedge aclk);
        cfg_we <= 1'b0;
        case (idx)
            REG_POINT_COUNT: shadow_count = value[2:0];
            REG_CHAN_MIN:    shadow_min = value[47:0];
            REG_CHAN_MAX:    shadow_max = value[47:0];
            default:         shadow_points[int'(idx) - 1] = value;
        endcase
        @(posedge aclk);
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        while (pending_pixels.size() != 0) @(posedge aclk);
        repeat (LATENCY_WAIT) @(posedge aclk);
    endtask

    function automatic logic [55:0] make_point(logic [31:0] v, logic [23:0] bgr);
        return {v, bgr};
    endfunction

    // Result checker: compares each result transaction with the oldest expectation.
    always @(posedge aclk) begin
        rgb_t got;
        rgb_t want;
        if (aresetn && m_tvalid && m_tready) begin
            got = m_tdata;
            if (pending_pixels.size() == 0) begin
                $display("tb: unexpected result transaction at %0t", $realtime);
                error_count++;
            end else begin
                want = pending_pixels.pop_front();
                if (got.red != want.red) report_mismatch("red", got.red, want.red);
                if (got.green != want.green) report_mismatch("green", got.green, want.green);
                if (got.blue != want.blue) report_mismatch("blue", got.blue, want.blue);
            end
        end
    end

    // Receiver: random stalls, plus one long hold-off on request.
    always @(posedge aclk) begin
        if (!aresetn || hold_off) begin
            m_tready <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(0, 3) != 0);
        end
    end

    initial begin
        int stall_cycles;
        hold_off = 1'b0;
        wait (aresetn === 1'b1);
        repeat (200) @(posedge aclk);
        hold_off = 1'b1;
        stall_cycles = 0;
        while (stall_cycles < 300) begin
            @(posedge aclk);
            stall_cycles++;
        end
        hold_off = 1'b0;
    end

    // Directed: gray, bgr, and normalize extremes with reset registers.
    task automatic test_fixed_modes();
        send_pixel(MODE_GRAY, pack_pixel(32'h0000_0000, 16'd0, 16'd0, 16'd0), 1'b0);
        send_pixel(MODE_GRAY, pack_pixel(32'hFFFF_FFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF), 1'b0);
        send_pixel(MODE_GRAY, pack_pixel(32'h1234_5680, 16'd0, 16'd0, 16'd0), 1'b0);
        send_pixel(MODE_BGR, pack_pixel(32'd0, 16'h00FF, 16'hFF00, 16'h8001), 1'b0);
        send_pixel(MODE_BGR, pack_pixel(32'hFFFF_FFFF, 16'hAB12, 16'h5634, 16'hFFFF), 1'b0);
        send_pixel(MODE_NORM, pack_pixel(32'd0, 16'h8000, 16'h7FFF, 16'h0000), 1'b0);
        send_pixel(MODE_NORM, pack_pixel(32'd0, 16'h8100, 16'h7F00, 16'h0080), 1'b0);
        send_pixel(MODE_NORM, pack_pixel(32'd0, 16'h0001, 16'hFFFF, 16'h7E00), 1'b0);
        drain();
    endtask

    // Directed: colormap below, between, on and above the reset breakpoints.
    task automatic test_colormap_edges();
        send_pixel(MODE_SCALAR, pack_pixel(32'h8000_0000, 16'd0, 16'd0, 16'd0), 1'b0);
        send_pixel(MODE_SCALAR, pack_pixel(32'h0000_0000, 16'd0, 16'd0, 16'd0), 1'b0);
        send_pixel(MODE_SCALAR, pack_pixel(32'h0000_0001, 16'd0, 16'd0, 16'd0), 1'b0);
        send_pixel(MODE_SCALAR, pack_pixel(32'h0000_8000, 16'd0, 16'd0, 16'd0), 1'b0);
        send_pixel(MODE_SCALAR, pack_pixel(32'h0001_0000, 16'd0, 16'd0, 16'd0), 1'b0);
        send_pixel(MODE_SCALAR, pack_pixel(32'h7FFF_FFFF, 16'd0, 16'd0, 16'd0), 1'b0);
        drain();
        // Widest span with five points, including unsorted entries.
        write_reg(REG_POINT_COUNT, 56'd5);
        write_reg(REG_POINT_0, make_point(32'h8000_0000, 24'h0000FF));
        write_reg(REG_POINT_1, make_point(32'h7FFF_FFFF, 24'hFF00FF));
        write_reg(REG_POINT_2, make_point(32'h0000_0000, 24'h00FF00));
        write_reg(REG_POINT_3, make_point(32'h0002_0000, 24'hFFFFFF));
        write_reg(REG_POINT_4, make_point(32'h7FFF_FFFF, 24'h123456));
        send_pixel(MODE_SCALAR, pack_pixel(32'h8000_0000, 16'd0, 16'd0, 16'd0), 1'b0);
        send_pixel(MODE_SCALAR, pack_pixel(32'h8000_0001, 16'd0, 16'd0, 16'd0), 1'b0);
        send_pixel(MODE_SCALAR, pack_pixel(32'h0000_0000, 16'd0, 16'd0, 16'd0), 1'b0);
        send_pixel(MODE_SCALAR, pack_pixel(32'h7FFF_FFFF, 16'd0, 16'd0, 16'd0), 1'b0);
        drain();
        // Out-of-range point counts act as one and as the maximum.
        write_reg(REG_POINT_COUNT, 56'd0);
        send_pixel(MODE_SCALAR, pack_pixel(32'h0001_0000, 16'd0, 16'd0, 16'd0), 1'b0);
        drain();
        write_reg(REG_POINT_COUNT, 56'd7);
        send_pixel(MODE_SCALAR, pack_pixel(32'h0001_0000, 16'd0, 16'd0, 16'd0), 1'b0);
        drain();
        // Empty, inverted and full-width normalize ranges.
        write_reg(REG_CHAN_MIN, {8'd0, 16'h0100, 16'h7FFF, 16'h8000});
        write_reg(REG_CHAN_MAX, {8'd0, 16'h0100, 16'h8000, 16'h7FFF});
        send_pixel(MODE_NORM, pack_pixel(32'd0, 16'h7FFF, 16'h0000, 16'h0100), 1'b0);
        send_pixel(MODE_NORM, pack_pixel(32'd0, 16'h0000, 16'h7FFF, 16'h8000), 1'b0);
        drain();
    endtask

    function automatic logic [31:0] rand_value();
        case ($urandom_range(0, 3))
            0: return $urandom();
            1: return 32'($signed($urandom_range(0, 8 << 16)) - (4 << 16));
            2: return $urandom_range(0, 3) == 0 ? 32'h7FFF_FFFF : 32'h8000_0000;
            default: return 32'($signed($urandom_range(0, 512)) - 256);
        endcase
    endfunction

    // Random phases, each with a fresh register setting.
    task automatic test_random_phases();
        int phase;
        int item;
        int p;
        int j;
        logic [31:0] vals [MAX_POINTS];
        logic [31:0] tmp;
        for (phase = 0; phase < 10; phase++) begin
            for (p = 0; p < MAX_POINTS; p++) vals[p] = rand_value();
            // Mostly sorted breakpoints; some phases keep them as drawn.
            if (phase % 3 != 2) begin
                for (p = 0; p < MAX_POINTS; p++)
                    for (j = 0; j < MAX_POINTS - 1 - p; j++)
                        if ($signed(vals[j]) > $signed(vals[j+1])) begin
                            tmp = vals[j];
                            vals[j] = vals[j+1];
                            vals[j+1] = tmp;
                        end
            end
            write_reg(REG_POINT_COUNT, 56'($urandom_range(0, 7)));
            write_reg(REG_POINT_0, make_point(vals[0], 24'($urandom())));
            write_reg(REG_POINT_1, make_point(vals[1], 24'($urandom())));
            write_reg(REG_POINT_2, make_point(vals[2], 24'($urandom())));
            write_reg(REG_POINT_3, make_point(vals[3], 24'($urandom())));
            write_reg(REG_POINT_4, make_point(vals[4], 24'($urandom())));
            write_reg(REG_CHAN_MIN, 56'({$urandom(), $urandom()} & 64'hFFFF_FFFF_FFFF)
                                    & 56'h0000_FFFF_FFFF_FFFF);
            write_reg(REG_CHAN_MAX, 56'({$urandom(), $urandom()} & 64'hFFFF_FFFF_FFFF)
                                    & 56'h0000_FFFF_FFFF_FFFF);
            for (item = 0; item < RANDOM_ITEMS / 10; item++) begin
                if ($urandom_range(0, 2) == 0) begin
                    send_pixel(MODE_SCALAR, pack_pixel(vals[$urandom_range(0, 4)]
                        + 32'($signed($urandom_range(0, 4)) - 2),
                        16'($urandom()), 16'($urandom()), 16'($urandom())),
                        item > 20);
                end else begin
                    send_pixel(mode_t'($urandom_range(0, 3)),
                        pack_pixel(rand_value(), 16'($urandom()), 16'($urandom()),
                                   16'($urandom())), item > 20);
                end
            end
            drain();
        end
    endtask

    initial begin
        aresetn   = 1'b0;
        s_tvalid  = 1'b0;
        s_tuser   = MODE_GRAY;
        s_tdata   = '0;
        cfg_we    = 1'b0;
        cfg_index = REG_POINT_COUNT;
        cfg_wdata = '0;
        error_count = 0;
        shadow_count = 3'd2;
        foreach (shadow_points[i]) shadow_points[i] = '0;
        shadow_points[1] = PT1_RESET;
        shadow_min = CMIN_RESET;
        shadow_max = CMAX_RESET;
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_fixed_modes();
        test_colormap_edges();
        test_random_phases();
        drain();
        if (error_count == 0) begin
            $display("tb: clean");
        end else begin
            $display("tb: errors");
        end
        $finish;
    end

    // Watchdog for a hung handshake.
    initial begin
        #3ms;
        $display("tb: errors");
        $finish;
    end

endmodule
